// ===== sv/mats_pkg.sv =====
// ----------------------------------------------------------------------------
// mats_pkg
// Shared types and constants for the five-axis timed step scheduler.
// ----------------------------------------------------------------------------
package mats_pkg;

   localparam int AXES          = 5;
   localparam int STEP_W        = 24;
   localparam int DUR_W         = 20;
   localparam int LIM_W         = 6;
   localparam int POS_W         = 32;
   localparam int ELAP_W        = 21;
   localparam int TIME_STEP     = 2;
   localparam int FRAC_BITS_DEF = 16;

   // request commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // active-low end switch bit positions
   localparam int LIM_XMIN = 0;
   localparam int LIM_XMAX = 1;
   localparam int LIM_YMIN = 2;
   localparam int LIM_YMAX = 3;
   localparam int LIM_ZMIN = 4;
   localparam int LIM_ZMAX = 5;

   typedef struct packed {
      logic                     cmd;
      logic signed [STEP_W-1:0] steps_x;
      logic signed [STEP_W-1:0] steps_y;
      logic signed [STEP_W-1:0] steps_z;
      logic signed [STEP_W-1:0] steps_p;
      logic signed [STEP_W-1:0] steps_b;
      logic        [DUR_W-1:0]  duration_ms;
      logic        [LIM_W-1:0]  limit_bits;
   } req_type;

   typedef struct packed {
      logic        [AXES-1:0]  step_mask;
      logic        [AXES-1:0]  dir_mask;
      logic                    move_active;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [POS_W-1:0] pos_p;
      logic signed [POS_W-1:0] pos_b;
   } rsp_type;

endpackage

// ===== sv/multi_axis_timed_step_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// multi_axis_timed_step_scheduler_core
// Five-axis coordinated step generator with bit-serial interval dividers.
// ----------------------------------------------------------------------------
// Tick request: result registered into the output register or skid entry; ticks
//   can be accepted back to back, one per cycle, while the result buffer has room.
// Load request: result pushed when the restoring divider finishes; it retires one
//   quotient bit per cycle in each of the five parallel axis lanes, and no
//   request is accepted while it runs.
// Reset (synchronous): move stopped, positions zero, all axes idle, directions forward.
module multi_axis_timed_step_scheduler_core #(
   parameter int FRAC_BITS = mats_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mats_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mats_pkg::rsp_type rsp_data
);

   localparam int AXES   = mats_pkg::AXES;
   localparam int STEP_W = mats_pkg::STEP_W;
   localparam int DUR_W  = mats_pkg::DUR_W;
   localparam int POS_W  = mats_pkg::POS_W;
   localparam int ELAP_W = mats_pkg::ELAP_W;
   localparam int DIV_W  = DUR_W + FRAC_BITS;
   localparam int NEXT_W = ELAP_W + FRAC_BITS + 3;
   localparam int CNT_W  = $clog2(DIV_W);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DIV  = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [ELAP_W-1:0]       elapsed_ff, elapsed_in;
   logic [DUR_W-1:0]        mlen_ff, mlen_in;
   logic                    running_ff, running_in;
   logic [AXES-1:0]         dir_ff, dir_in;
   logic [AXES-1:0]         idle_ff, idle_in;
   logic [DIV_W-1:0]        int_ff [AXES];
   logic [DIV_W-1:0]        int_in [AXES];
   logic [NEXT_W-1:0]       next_ff [AXES];
   logic [NEXT_W-1:0]       next_in [AXES];
   logic [POS_W-1:0]        pos_ff [AXES];
   logic [POS_W-1:0]        pos_in [AXES];
   logic [DIV_W-1:0]        quo_ff [AXES];
   logic [DIV_W-1:0]        quo_in [AXES];
   logic [STEP_W-1:0]       rem_ff [AXES];
   logic [STEP_W-1:0]       rem_in [AXES];
   logic [STEP_W-1:0]       dvsr_ff [AXES];
   logic [STEP_W-1:0]       dvsr_in [AXES];

   mats_pkg::rsp_type       out_ff, out_in, skid_ff, skid_in, rsp_new;
   logic                    out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;

   logic                    acc, is_load, is_tick, div_last, push, pop;
   logic [STEP_W-1:0]       steps_w [AXES];
   logic [STEP_W-1:0]       mag_w [AXES];
   logic [AXES-1:0]         held, due;
   logic [ELAP_W-1:0]       elapsed_add;
   logic [NEXT_W-1:0]       tfix;
   logic [STEP_W:0]         rem_sh [AXES];
   logic [STEP_W:0]         diff_w [AXES];
   logic [AXES-1:0]         ge_w;
   logic [DIV_W-1:0]        quo_step [AXES];
   logic [STEP_W-1:0]       rem_step [AXES];

   assign req_stall = (state_ff == ST_DIV) | (out_vld_ff & skid_vld_ff);
   assign acc       = req_valid & ~req_stall;
   assign is_load   = acc & (req_data.cmd == mats_pkg::CMD_LOAD);
   assign is_tick   = acc & (req_data.cmd == mats_pkg::CMD_TICK);
   assign div_last  = (state_ff == ST_DIV) && (cnt_ff == CNT_W'(DIV_W - 1));
   assign push      = is_tick | div_last;
   assign pop       = out_vld_ff & ~rsp_stall;

   assign steps_w[0] = req_data.steps_x;
   assign steps_w[1] = req_data.steps_y;
   assign steps_w[2] = req_data.steps_z;
   assign steps_w[3] = req_data.steps_p;
   assign steps_w[4] = req_data.steps_b;

   // Z is wired with max on the negative end
   always_comb begin
      held    = '0;
      held[0] = (~req_data.limit_bits[mats_pkg::LIM_XMIN] & ~dir_ff[0]) |
                (~req_data.limit_bits[mats_pkg::LIM_XMAX] &  dir_ff[0]);
      held[1] = (~req_data.limit_bits[mats_pkg::LIM_YMIN] & ~dir_ff[1]) |
                (~req_data.limit_bits[mats_pkg::LIM_YMAX] &  dir_ff[1]);
      held[2] = (~req_data.limit_bits[mats_pkg::LIM_ZMAX] & ~dir_ff[2]) |
                (~req_data.limit_bits[mats_pkg::LIM_ZMIN] &  dir_ff[2]);
   end

   assign elapsed_add = ELAP_W'(elapsed_ff + ELAP_W'(mats_pkg::TIME_STEP));
   assign tfix        = NEXT_W'({elapsed_add, {FRAC_BITS{1'b0}}});

   // per-lane compare and one restoring divide step
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         mag_w[i]    = steps_w[i][STEP_W-1] ? STEP_W'(-steps_w[i]) : steps_w[i];
         due[i]      = running_ff & ~idle_ff[i] & (tfix >= next_ff[i]) & ~held[i];
         rem_sh[i]   = {rem_ff[i], quo_ff[i][DIV_W-1]};
         diff_w[i]   = rem_sh[i] - {1'b0, dvsr_ff[i]};
         ge_w[i]     = rem_sh[i] >= {1'b0, dvsr_ff[i]};
         rem_step[i] = ge_w[i] ? diff_w[i][STEP_W-1:0] : rem_sh[i][STEP_W-1:0];
         quo_step[i] = {quo_ff[i][DIV_W-2:0], ge_w[i]};
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      elapsed_in = elapsed_ff;
      mlen_in    = mlen_ff;
      running_in = running_ff;
      dir_in     = dir_ff;
      idle_in    = idle_ff;
      int_in     = int_ff;
      next_in    = next_ff;
      pos_in     = pos_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      dvsr_in    = dvsr_ff;

      if (is_load) begin
         state_in   = ST_DIV;
         cnt_in     = '0;
         elapsed_in = '0;
         mlen_in    = req_data.duration_ms;
         running_in = 1'b1;
         for (int i = 0; i < AXES; i++) begin
            dir_in[i]  = ~steps_w[i][STEP_W-1];
            idle_in[i] = (steps_w[i] == '0);
            quo_in[i]  = {req_data.duration_ms, {FRAC_BITS{1'b0}}};
            rem_in[i]  = '0;
            dvsr_in[i] = mag_w[i];
         end
      end

      if (is_tick && running_ff) begin
         elapsed_in = elapsed_add;
         running_in = elapsed_add <= ELAP_W'(mlen_ff);
         for (int i = 0; i < AXES; i++) begin
            if (due[i]) begin
               next_in[i] = next_ff[i] + NEXT_W'(int_ff[i]);
               pos_in[i]  = dir_ff[i] ? pos_ff[i] + POS_W'(1) : pos_ff[i] - POS_W'(1);
            end
         end
      end

      if (state_ff == ST_DIV) begin
         cnt_in = cnt_ff + CNT_W'(1);
         quo_in = quo_step;
         rem_in = rem_step;
         if (div_last) begin
            state_in = ST_IDLE;
            for (int i = 0; i < AXES; i++) begin
               int_in[i]  = idle_ff[i] ? '0 : quo_step[i];
               next_in[i] = idle_ff[i] ? '0 : NEXT_W'(quo_step[i]);
            end
         end
      end
   end

   always_comb begin
      rsp_new.step_mask   = is_tick ? due : '0;
      rsp_new.dir_mask    = dir_ff;
      rsp_new.move_active = running_in;
      rsp_new.pos_x       = pos_in[0];
      rsp_new.pos_y       = pos_in[1];
      rsp_new.pos_z       = pos_in[2];
      rsp_new.pos_p       = pos_in[3];
      rsp_new.pos_b       = pos_in[4];
   end

   // two-entry result buffer: output register plus skid
   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (pop && skid_vld_ff) begin
         out_in = skid_ff;
         if (push) begin
            skid_in = rsp_new;
         end else begin
            skid_vld_in = 1'b0;
         end
      end else if (pop) begin
         out_in     = rsp_new;
         out_vld_in = push;
      end else if (push) begin
         if (!out_vld_ff) begin
            out_in     = rsp_new;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = rsp_new;
            skid_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         elapsed_ff  <= '0;
         mlen_ff     <= '0;
         running_ff  <= 1'b0;
         dir_ff      <= '1;
         idle_ff     <= '1;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            int_ff[i]  <= '0;
            next_ff[i] <= '0;
            pos_ff[i]  <= '0;
         end
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         elapsed_ff  <= elapsed_in;
         mlen_ff     <= mlen_in;
         running_ff  <= running_in;
         dir_ff      <= dir_in;
         idle_ff     <= idle_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
         int_ff      <= int_in;
         next_ff     <= next_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_load_result: assert property (@(posedge clock) disable iff (reset)
      is_load |-> ##DIV_W div_last)
      else $error("load request did not finish its divide on time");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry held while output register empty");

   a_idle_axis: assert property (@(posedge clock) disable iff (reset)
      push |-> ((rsp_new.step_mask & idle_ff) == '0))
      else $error("idle axis produced a step");

   a_stopped_tick: assert property (@(posedge clock) disable iff (reset)
      (is_tick && !running_ff) |-> (rsp_new.step_mask == '0 && !rsp_new.move_active))
      else $error("tick outside a move changed step state");

endmodule

// ===== tb/multi_axis_timed_step_scheduler_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_axis_timed_step_scheduler_core_test
// Drives load and tick requests into the five-axis step scheduler and checks
// every status result against a cycle-free model of the step timing, limit
// switches and position counters. Both channels idle at random in phases.
// ----------------------------------------------------------------------------
module multi_axis_timed_step_scheduler_core_test;
   import mats_pkg::*;

   localparam int NEXT_W = 40;
   localparam int IVL_W  = DUR_W + FRAC_BITS_DEF;
   localparam int TFIX_W = ELAP_W + FRAC_BITS_DEF;
   localparam logic [LIM_W-1:0] LIM_OPEN = '1;

   class step_motion_scoreboard;
      logic [ELAP_W-1:0] elapsed_ms;
      logic [DUR_W-1:0]  move_ms;
      logic              running;
      logic [IVL_W-1:0]  interval[AXES];
      logic [NEXT_W-1:0] next_due[AXES];
      logic [AXES-1:0]   idle;
      logic [AXES-1:0]   forward;
      logic [POS_W-1:0]  position[AXES];
      rsp_type           pending_status[$];
      int mismatches, checked, loads, ticks, step_count;

      function new();
         elapsed_ms = '0;
         move_ms    = '0;
         running    = 1'b0;
         idle       = '1;
         forward    = '1;
         for (int i = 0; i < AXES; i++) begin
            interval[i] = '0;
            next_due[i] = '0;
            position[i] = '0;
         end
         mismatches = 0;
         checked    = 0;
         loads      = 0;
         ticks      = 0;
         step_count = 0;
      endfunction

      function logic [AXES-1:0] held_axes(logic [LIM_W-1:0] lim);
         logic [AXES-1:0] h;
         h = '0;
         h[0] = (!lim[LIM_XMIN] && !forward[0]) || (!lim[LIM_XMAX] && forward[0]);
         h[1] = (!lim[LIM_YMIN] && !forward[1]) || (!lim[LIM_YMAX] && forward[1]);
         // Z switches face the other way
         h[2] = (!lim[LIM_ZMAX] && !forward[2]) || (!lim[LIM_ZMIN] && forward[2]);
         return h;
      endfunction

      function void note_request(req_type r);
         logic signed [STEP_W-1:0] req_steps[AXES];
         logic [STEP_W-1:0]        mag;
         logic [TFIX_W-1:0]        now_fix;
         logic [AXES-1:0]          held;
         logic [AXES-1:0]          fired;
         rsp_type                  e;
         req_steps[0] = r.steps_x;
         req_steps[1] = r.steps_y;
         req_steps[2] = r.steps_z;
         req_steps[3] = r.steps_p;
         req_steps[4] = r.steps_b;
         fired = '0;
         if (r.cmd == CMD_LOAD) begin
            loads++;
            for (int i = 0; i < AXES; i++) begin
               forward[i] = !req_steps[i][STEP_W-1];
               mag = req_steps[i][STEP_W-1] ? ~req_steps[i] + 1'b1 : req_steps[i];
               if (mag == 0) begin
                  idle[i]     = 1'b1;
                  interval[i] = '0;
                  next_due[i] = '0;
               end else begin
                  idle[i]     = 1'b0;
                  interval[i] = {r.duration_ms, {FRAC_BITS_DEF{1'b0}}} / mag;
                  next_due[i] = NEXT_W'(interval[i]);
               end
            end
            elapsed_ms = '0;
            move_ms    = r.duration_ms;
            running    = 1'b1;
         end else begin
            ticks++;
            if (running) begin
               elapsed_ms = elapsed_ms + ELAP_W'(TIME_STEP);
               now_fix    = {elapsed_ms, {FRAC_BITS_DEF{1'b0}}};
               held       = held_axes(r.limit_bits);
               for (int i = 0; i < AXES; i++) begin
                  if (!idle[i] && now_fix >= next_due[i] && !held[i]) begin
                     fired[i]    = 1'b1;
                     next_due[i] = next_due[i] + interval[i];
                     position[i] = forward[i] ? position[i] + 1 : position[i] - 1;
                  end
               end
               running = elapsed_ms <= move_ms;
            end
         end
         step_count += $countones(fired);
         e.step_mask   = fired;
         e.dir_mask    = forward;
         e.move_active = running;
         e.pos_x       = position[0];
         e.pos_y       = position[1];
         e.pos_z       = position[2];
         e.pos_p       = position[3];
         e.pos_b       = position[4];
         pending_status.push_back(e);
      endfunction

      task report(string msg);
         mismatches++;
         $display("mismatch at %0t: %s", $time, msg);
      endtask

      task check_status(rsp_type got);
         rsp_type e;
         if (pending_status.size() == 0) begin
            report("result with no request outstanding");
            return;
         end
         e = pending_status.pop_front();
         checked++;
         if (got.step_mask !== e.step_mask)
            report($sformatf("step_mask %b, expected %b", got.step_mask, e.step_mask));
         if (got.dir_mask !== e.dir_mask)
            report($sformatf("dir_mask %b, expected %b", got.dir_mask, e.dir_mask));
         if (got.move_active !== e.move_active)
            report($sformatf("move_active %b, expected %b", got.move_active, e.move_active));
         if (got.pos_x !== e.pos_x)
            report($sformatf("pos_x %0d, expected %0d", got.pos_x, e.pos_x));
         if (got.pos_y !== e.pos_y)
            report($sformatf("pos_y %0d, expected %0d", got.pos_y, e.pos_y));
         if (got.pos_z !== e.pos_z)
            report($sformatf("pos_z %0d, expected %0d", got.pos_z, e.pos_z));
         if (got.pos_p !== e.pos_p)
            report($sformatf("pos_p %0d, expected %0d", got.pos_p, e.pos_p));
         if (got.pos_b !== e.pos_b)
            report($sformatf("pos_b %0d, expected %0d", got.pos_b, e.pos_b));
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 0;
   int hold_idle_pct = 0;

   step_motion_scoreboard board;

   multi_axis_timed_step_scheduler_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < hold_idle_pct);
   end

   // results are checked before the request of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_status(rsp_data);
         if (req_valid && !req_stall)
            board.note_request(req_data);
      end
   end

   function automatic req_type make_load(logic signed [STEP_W-1:0] sx,
                                         logic signed [STEP_W-1:0] sy,
                                         logic signed [STEP_W-1:0] sz,
                                         logic signed [STEP_W-1:0] sp,
                                         logic signed [STEP_W-1:0] sb,
                                         logic [DUR_W-1:0] dur);
      req_type r;
      r.cmd         = CMD_LOAD;
      r.steps_x     = sx;
      r.steps_y     = sy;
      r.steps_z     = sz;
      r.steps_p     = sp;
      r.steps_b     = sb;
      r.duration_ms = dur;
      r.limit_bits  = LIM_W'($urandom);
      return r;
   endfunction

   // move fields carry junk on a tick; the block must ignore them
   function automatic req_type make_tick(logic [LIM_W-1:0] lim);
      req_type r;
      r.cmd         = CMD_TICK;
      r.steps_x     = STEP_W'($urandom);
      r.steps_y     = STEP_W'($urandom);
      r.steps_z     = STEP_W'($urandom);
      r.steps_p     = STEP_W'($urandom);
      r.steps_b     = STEP_W'($urandom);
      r.duration_ms = DUR_W'($urandom);
      r.limit_bits  = lim;
      return r;
   endfunction

   function automatic logic signed [STEP_W-1:0] rand_steps();
      int m;
      int v;
      m = $urandom_range(99);
      if (m < 15)
         return '0;
      v = (m < 70) ? $urandom_range(12) : (m < 90) ? $urandom_range(2000) : $urandom;
      if ($urandom_range(1))
         v = -v;
      return STEP_W'(v);
   endfunction

   function automatic logic [LIM_W-1:0] rand_limits();
      return ($urandom_range(3) == 0) ? LIM_W'($urandom_range(63)) : LIM_OPEN;
   endfunction

   task send_req(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // mostly complete moves with random content, some cut short, some junk
   task run_random(int budget);
      int sent;
      int m;
      int dur;
      int n;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(1))
               send_req(make_load(STEP_W'($urandom), STEP_W'($urandom), STEP_W'($urandom),
                                  STEP_W'($urandom), STEP_W'($urandom), DUR_W'($urandom)));
            else
               send_req(make_tick(LIM_W'($urandom)));
            sent++;
         end else begin
            m = $urandom_range(99);
            dur = (m < 10) ? 0 : (m < 75) ? $urandom_range(40, 1) :
                  (m < 95) ? $urandom_range(120, 41) : $urandom_range(300, 121);
            send_req(make_load(rand_steps(), rand_steps(), rand_steps(), rand_steps(),
                               rand_steps(), DUR_W'(dur)));
            n = dur / TIME_STEP + 1;
            if ($urandom_range(9) == 0)
               n = $urandom_range(n);
            sent += n + 1;
            repeat (n) send_req(make_tick(rand_limits()));
            // ticks after the move has ended
            repeat ($urandom_range(2)) send_req(make_tick(rand_limits()));
         end
      end
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 27;
      hold_idle_pct = 77;

      // tick with no move loaded
      send_req(make_tick(LIM_OPEN));
      // extreme counts, idle axis, zero duration
      send_req(make_load(8388607, STEP_W'(-8388608), 0, 1, STEP_W'(-1), 0));
      send_req(make_tick(LIM_OPEN));
      send_req(make_tick(LIM_OPEN));
      // forward move against switches
      send_req(make_load(5, 5, 5, 5, 5, 10));
      send_req(make_tick('0));
      send_req(make_tick(~LIM_W'((1 << LIM_XMIN) | (1 << LIM_YMIN) | (1 << LIM_ZMAX))));
      send_req(make_tick(LIM_OPEN));
      send_req(make_tick(LIM_OPEN));
      // backward move against switches
      send_req(make_load(STEP_W'(-3), STEP_W'(-3), STEP_W'(-3), STEP_W'(-3),
                         STEP_W'(-3), 6));
      send_req(make_tick(~LIM_W'((1 << LIM_XMAX) | (1 << LIM_YMAX) | (1 << LIM_ZMAX))));
      send_req(make_tick(~LIM_W'((1 << LIM_XMIN) | (1 << LIM_YMIN) | (1 << LIM_ZMIN))));
      send_req(make_tick(LIM_OPEN));
      // longest move, then replaced by a new load mid-move
      send_req(make_load(8388607, STEP_W'(-8388608), 1, 0, 7, '1));
      send_req(make_tick(LIM_OPEN));
      send_req(make_tick(LIM_OPEN));
      send_req(make_load(2, STEP_W'(-2), 3, STEP_W'(-4), 0, 4));
      repeat (4) send_req(make_tick(LIM_OPEN));

      run_random(170);
      send_idle_pct = 77;
      hold_idle_pct = 27;
      run_random(180);
      send_idle_pct = 0;
      hold_idle_pct = 0;
      run_random(180);
      req_valid <= 1'b0;

      while (board.pending_status.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      $display("checked %0d results from %0d loads and %0d ticks", board.checked,
               board.loads, board.ticks);
      $display("%0d axis steps predicted, %0d mismatches", board.step_count,
               board.mismatches);
      if (board.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting for the block");
      $display("simulation failed");
      $finish;
   end

endmodule
